[rtl/core/qacp_pkg.sv]
// Shared types, constants, gain table and microcode for the attitude cascade controller.
package qacp_pkg;

	// field widths
	localparam int ANG_W   = 17;
	localparam int RATE_W  = 20;
	localparam int CEIL_W  = 20;
	localparam int BOUND_W = 15;
	localparam int MOT_W   = 17;
	localparam int AXIS_W  = 16;
	localparam int GAIN_W  = 19;
	localparam int NAXES   = 3;

	// default fraction width and raw reset values of the clamps
	localparam int FRAC_BITS_DEF     = 8;
	localparam int INTEG_RESET_RAW   = 4000;
	localparam int BOUND_RESET_RAW   = 80;

	// register indexes
	localparam logic [2:0] REG_PITCH_TGT = 3'd0;
	localparam logic [2:0] REG_ROLL_TGT  = 3'd1;
	localparam logic [2:0] REG_YAW_TGT   = 3'd2;
	localparam logic [2:0] REG_INT_CEIL  = 3'd3;
	localparam logic [2:0] REG_OUT_BOUND = 3'd4;

	// axis codes
	localparam logic [1:0] AXIS_PITCH = 2'd0;
	localparam logic [1:0] AXIS_ROLL  = 2'd1;
	localparam logic [1:0] AXIS_YAW   = 2'd2;

	// program length
	localparam int            NSTEPS   = 11;
	localparam int            STEP_W   = $clog2(NSTEPS);
	localparam logic [STEP_W-1:0] STEP_MIX = STEP_W'(NSTEPS - 1);

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ERR,
		OP_RERR,
		OP_INTEG,
		OP_ACC_LD,
		OP_ACC_ADD,
		OP_ACC_SUB,
		OP_AXIS,
		OP_MIX
	} op_t;

	typedef enum logic [1:0] {
		A_AERR,
		A_RERR,
		A_INTEG,
		A_DIFF
	} a_sel_t;

	typedef enum logic [2:0] {
		K_OUTER,
		K_DT,
		K_P,
		K_I,
		K_D
	} k_sel_t;

	// one control word
	typedef struct packed {
		op_t    op;
		logic   mul_en;
		a_sel_t a_sel;
		k_sel_t k_sel;
		logic   loop;
	} ucode_t;

	// sequencer to datapath
	typedef struct packed {
		ucode_t     uc;
		logic [1:0] axis;
		logic       en;
	} ctrl_t;

	// operands of the current axis
	typedef struct packed {
		logic signed [ANG_W-1:0]  target;
		logic signed [ANG_W-1:0]  angle;
		logic signed [ANG_W-1:0]  offset;
		logic signed [RATE_W-1:0] rate;
	} axis_ops_t;

	// unsigned Q.16 gains, plain integer outer gains
	function automatic logic [GAIN_W-1:0] gain_lookup(logic [1:0] axis, k_sel_t k);
		logic yaw;
		logic [GAIN_W-1:0] g;
		yaw = (axis == AXIS_YAW);
		case (k)
			K_OUTER: g = yaw ? GAIN_W'(33) : GAIN_W'(43);
			K_DT:    g = GAIN_W'(131);
			K_P: begin
				case (axis)
					AXIS_PITCH: g = GAIN_W'(6318);
					AXIS_ROLL:  g = GAIN_W'(6324);
					default:    g = GAIN_W'(41943);
				endcase
			end
			K_I:     g = yaw ? GAIN_W'(105) : GAIN_W'(25775);
			K_D:     g = yaw ? GAIN_W'(10486) : GAIN_W'(308019);
			default: g = '0;
		endcase
		return g;
	endfunction

	// control program: ten steps per axis, then the mixer
	function automatic ucode_t ucode_fetch(logic [STEP_W-1:0] step);
		ucode_t u;
		u = '{op: OP_NONE, mul_en: 1'b0, a_sel: A_AERR, k_sel: K_OUTER, loop: 1'b0};
		case (step)
			4'd0: u.op = OP_ERR;
			4'd1: begin
				u.mul_en = 1'b1; u.a_sel = A_AERR; u.k_sel = K_OUTER;
			end
			4'd2: u.op = OP_RERR;
			4'd3: begin
				u.mul_en = 1'b1; u.a_sel = A_RERR; u.k_sel = K_DT;
			end
			4'd4: u.op = OP_INTEG;
			4'd5: begin
				u.mul_en = 1'b1; u.a_sel = A_RERR; u.k_sel = K_P;
			end
			4'd6: begin
				u.op = OP_ACC_LD; u.mul_en = 1'b1; u.a_sel = A_INTEG; u.k_sel = K_I;
			end
			4'd7: begin
				u.op = OP_ACC_ADD; u.mul_en = 1'b1; u.a_sel = A_DIFF; u.k_sel = K_D;
			end
			4'd8: u.op = OP_ACC_SUB;
			4'd9: begin
				u.op = OP_AXIS; u.loop = 1'b1;
			end
			4'd10: u.op = OP_MIX;
			default: u.op = OP_NONE;
		endcase
		return u;
	endfunction

endpackage

[rtl/core/quad_attitude_cascade_pid.sv]
// Cascaded angle/rate attitude controller: stream ports, register file and step sequencer.
// The result is computed in ten steps per axis on the shared multiplier and accumulator,
// then one mixing step. A new item is not taken while one is in progress; the next
// item is taken once mixing has loaded the output register, which holds the result
// until the downstream transfer.
// Reset (arst_n low, asynchronous) clears integrals, previous rates, the sequencer
// and the output valid, and sets the registers to their defaults.
module quad_attitude_cascade_pid #(
	parameter int FRAC_BITS = qacp_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// config port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata, from bit 0: pitch_angle, roll_angle, yaw_angle (17 each),
	// pitch_rate, roll_rate, yaw_rate (20 each), pitch_offset, roll_offset,
	// yaw_offset (17 each), zero fill to 168 bits
	input  logic [167:0] s_tdata,
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata, from bit 0: motor_front_a, motor_front_b, motor_rear_a,
	// motor_rear_b (17 each), zero fill to 72 bits
	output logic [71:0]  m_tdata
);
	import qacp_pkg::*;

	localparam int  IN_W       = 3 * ANG_W * 2 + 3 * RATE_W;
	localparam int  OUT_W      = 4 * MOT_W;
	localparam longint CEIL_SH  = longint'(INTEG_RESET_RAW) << FRAC_BITS;
	localparam longint BOUND_SH = longint'(BOUND_RESET_RAW) << FRAC_BITS;
	localparam longint CEIL_TOP  = (longint'(1) << CEIL_W) - 1;
	localparam longint BOUND_TOP = (longint'(1) << BOUND_W) - 1;
	localparam logic [CEIL_W-1:0]  CEIL_RST  =
		CEIL_W'((CEIL_SH > CEIL_TOP) ? CEIL_TOP : CEIL_SH);
	localparam logic [BOUND_W-1:0] BOUND_RST =
		BOUND_W'((BOUND_SH > BOUND_TOP) ? BOUND_TOP : BOUND_SH);

	logic signed [ANG_W-1:0] pitch_target_q, roll_target_q, yaw_target_q;
	logic [CEIL_W-1:0]       integral_ceiling_q;
	logic [BOUND_W-1:0]      axis_output_bound_q;

	logic [IN_W-1:0]   smp_q;
	logic [OUT_W-1:0]  out_q;
	logic              out_valid_q;
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        axis_q;

	ucode_t    uc;
	ctrl_t     ctrl;
	axis_ops_t ops;
	logic      in_xfer;
	logic      mix_fire;
	logic      cfg_wr;
	logic [2:0] cfg_idx;

	logic signed [MOT_W-1:0] mot_fa, mot_fb, mot_ra, mot_rb;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[4:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_target_q      <= '0;
			roll_target_q       <= '0;
			yaw_target_q        <= '0;
			integral_ceiling_q  <= CEIL_RST;
			axis_output_bound_q <= BOUND_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PITCH_TGT: pitch_target_q      <= pwdata[ANG_W-1:0];
				REG_ROLL_TGT:  roll_target_q       <= pwdata[ANG_W-1:0];
				REG_YAW_TGT:   yaw_target_q        <= pwdata[ANG_W-1:0];
				REG_INT_CEIL:  integral_ceiling_q  <= pwdata[CEIL_W-1:0];
				REG_OUT_BOUND: axis_output_bound_q <= pwdata[BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (cfg_idx)
			REG_PITCH_TGT: prdata = 32'(unsigned'(pitch_target_q));
			REG_ROLL_TGT:  prdata = 32'(unsigned'(roll_target_q));
			REG_YAW_TGT:   prdata = 32'(unsigned'(yaw_target_q));
			REG_INT_CEIL:  prdata = 32'(integral_ceiling_q);
			REG_OUT_BOUND: prdata = 32'(axis_output_bound_q);
			default:       prdata = '0;
		endcase
	end

	// handshakes
	assign s_tready = !busy_q;
	assign in_xfer  = s_tvalid && s_tready;
	assign uc       = ucode_fetch(step_q);
	assign mix_fire = busy_q && (uc.op == OP_MIX) && (!out_valid_q || m_tready);

	// sample capture
	always_ff @(posedge clk) begin
		if (in_xfer)
			smp_q <= s_tdata[IN_W-1:0];
	end

	// operands of the current axis
	always_comb begin
		case (axis_q)
			AXIS_PITCH: begin
				ops.target = pitch_target_q;
				ops.angle  = smp_q[16:0];
				ops.rate   = smp_q[70:51];
				ops.offset = smp_q[127:111];
			end
			AXIS_ROLL: begin
				ops.target = roll_target_q;
				ops.angle  = smp_q[33:17];
				ops.rate   = smp_q[90:71];
				ops.offset = smp_q[144:128];
			end
			default: begin
				ops.target = yaw_target_q;
				ops.angle  = smp_q[50:34];
				ops.rate   = smp_q[110:91];
				ops.offset = smp_q[161:145];
			end
		endcase
	end

	assign ctrl.uc   = uc;
	assign ctrl.axis = axis_q;
	assign ctrl.en   = busy_q;

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			axis_q      <= AXIS_PITCH;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				busy_q <= 1'b1;
				step_q <= '0;
				axis_q <= AXIS_PITCH;
			end else if (busy_q) begin
				if (uc.op == OP_MIX) begin
					if (mix_fire) begin
						busy_q <= 1'b0;
						step_q <= '0;
						axis_q <= AXIS_PITCH;
					end
				end else if (uc.loop && axis_q != AXIS_YAW) begin
					step_q <= '0;
					axis_q <= axis_q + 2'd1;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			if (mix_fire)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (mix_fire)
			out_q <= {mot_rb, mot_ra, mot_fb, mot_fa};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(72 - OUT_W)'(0), out_q};

	qacp_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.ops               (ops),
		.integral_ceiling  (integral_ceiling_q),
		.axis_output_bound (axis_output_bound_q),
		.motor_front_a     (mot_fa),
		.motor_front_b     (mot_fb),
		.motor_rear_a      (mot_ra),
		.motor_rear_b      (mot_rb)
	);

	// an accepted item starts the program at the first axis
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> busy_q && step_q == '0 && axis_q == AXIS_PITCH)
		else $error("sequencer did not start on input transfer");

	// a result only appears from the mixing step
	a_mix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(busy_q) && $past(step_q) == STEP_MIX)
		else $error("result raised outside the mixing step");

	// the step counter stays within the program
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_MIX && axis_q != 2'd3)
		else $error("step or axis counter out of range");

	// a waiting result is not overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("pending result lost");

endmodule

[rtl/core/qacp_datapath.sv]
// Shared multiplier, accumulator, per-axis state and motor mixer driven by the control word.
module qacp_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  qacp_pkg::ctrl_t                       ctrl,
	input  qacp_pkg::axis_ops_t                   ops,
	input  logic        [qacp_pkg::CEIL_W-1:0]    integral_ceiling,
	input  logic        [qacp_pkg::BOUND_W-1:0]   axis_output_bound,
	output logic signed [qacp_pkg::MOT_W-1:0]     motor_front_a,
	output logic signed [qacp_pkg::MOT_W-1:0]     motor_front_b,
	output logic signed [qacp_pkg::MOT_W-1:0]     motor_rear_a,
	output logic signed [qacp_pkg::MOT_W-1:0]     motor_rear_b
);
	import qacp_pkg::*;

	localparam int AERR_W = ANG_W + 2;
	localparam int DIFF_W = RATE_W + 1;
	localparam int RERR_W = 26;
	localparam int PROD_W = RERR_W + GAIN_W + 1;
	localparam int SUM_W  = CEIL_W + 2;
	localparam int RND_W  = 32;
	localparam int MIX_W  = AXIS_W + 2;

	// state per axis
	logic        [CEIL_W-1:0] integ_q [NAXES];
	logic signed [RATE_W-1:0] prev_q  [NAXES];

	// working registers
	logic signed [AERR_W-1:0] aerr_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [RERR_W-1:0] rerr_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [AXIS_W-1:0] ax_q [NAXES];

	logic signed [RERR_W-1:0] mul_a;
	logic signed [GAIN_W:0]   mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [PROD_W-1:0] acc_rnd;
	logic signed [SUM_W-1:0]  integ_sum;
	logic        [CEIL_W-1:0] integ_new;
	logic signed [RND_W-1:0]  ax_val;
	logic signed [RND_W-1:0]  bound_s;
	logic signed [AXIS_W-1:0] ax_new;
	logic        [CEIL_W-1:0] integ_cur;
	logic signed [RATE_W-1:0] prev_cur;

	assign integ_cur = integ_q[ctrl.axis];
	assign prev_cur  = prev_q[ctrl.axis];

	// multiplier operand selection
	always_comb begin
		case (ctrl.uc.a_sel)
			A_AERR:  mul_a = RERR_W'(aerr_q);
			A_RERR:  mul_a = rerr_q;
			A_INTEG: mul_a = $signed(RERR_W'(integ_cur));
			A_DIFF:  mul_a = RERR_W'(diff_q);
			default: mul_a = '0;
		endcase
		mul_b = $signed({1'b0, gain_lookup(ctrl.axis, ctrl.uc.k_sel)});
	end

	// full-width product; operands are sign-extended, so the array is 26 by 20
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// rounding half up on the Q.16 scale
	assign prod_rnd = (prod_q + PROD_W'(32768)) >>> 16;
	assign acc_rnd  = (acc_q + PROD_W'(32768)) >>> 16;

	// integral update with clamp to 0..ceiling
	always_comb begin
		integ_sum = $signed({2'b00, integ_cur}) + prod_rnd[SUM_W-1:0];
		if (integ_sum[SUM_W-1])
			integ_new = '0;
		else if (integ_sum > $signed({2'b00, integral_ceiling}))
			integ_new = integral_ceiling;
		else
			integ_new = integ_sum[CEIL_W-1:0];
	end

	// axis output clamp to +-bound
	always_comb begin
		ax_val  = acc_rnd[RND_W-1:0];
		bound_s = $signed(RND_W'(axis_output_bound));
		if (ax_val < -bound_s)
			ax_new = AXIS_W'(-bound_s);
		else if (ax_val > bound_s)
			ax_new = AXIS_W'(bound_s);
		else
			ax_new = ax_val[AXIS_W-1:0];
	end

	// integral and previous rate, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NAXES; i++) begin
				integ_q[i] <= '0;
				prev_q[i]  <= '0;
			end
		end else if (ctrl.en && ctrl.uc.op == OP_INTEG) begin
			integ_q[ctrl.axis] <= integ_new;
			prev_q[ctrl.axis]  <= ops.rate;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			if (ctrl.uc.mul_en)
				prod_q <= mul_p;
			case (ctrl.uc.op)
				OP_ERR: begin
					aerr_q <= AERR_W'(ops.target) + AERR_W'(ops.offset) - AERR_W'(ops.angle);
					diff_q <= DIFF_W'(ops.rate) - DIFF_W'(prev_cur);
				end
				OP_RERR:    rerr_q <= prod_q[RERR_W-1:0] - RERR_W'(ops.rate);
				OP_ACC_LD:  acc_q <= prod_q;
				OP_ACC_ADD: acc_q <= acc_q + prod_q;
				OP_ACC_SUB: acc_q <= acc_q - prod_q;
				OP_AXIS:    ax_q[ctrl.axis] <= ax_new;
				default: ;
			endcase
		end
	end

	// saturate a mixed sum into the motor range
	function automatic logic signed [MOT_W-1:0] sat_motor(logic signed [MIX_W-1:0] v);
		logic signed [MIX_W-1:0] hi;
		logic signed [MIX_W-1:0] lo;
		hi = MIX_W'((1 << (MOT_W - 1)) - 1);
		lo = -hi - MIX_W'(1);
		if (v > hi)
			return hi[MOT_W-1:0];
		else if (v < lo)
			return lo[MOT_W-1:0];
		return v[MOT_W-1:0];
	endfunction

	// motor mixer
	logic signed [MIX_W-1:0] p_x, r_x, y_x;
	assign p_x = MIX_W'(ax_q[AXIS_PITCH]);
	assign r_x = MIX_W'(ax_q[AXIS_ROLL]);
	assign y_x = MIX_W'(ax_q[AXIS_YAW]);

	assign motor_front_a = sat_motor( p_x - r_x + y_x);
	assign motor_front_b = sat_motor( p_x + r_x - y_x);
	assign motor_rear_a  = sat_motor(-p_x + r_x + y_x);
	assign motor_rear_b  = sat_motor(-p_x - r_x - y_x);

endmodule
